>>> hw/rtl/adnp_pkg.sv
// Package for the ASCII decimal number parser.
// Holds character codes, phase and status codes, the result word type and
// the fraction weight table. No dependencies.
package adnp_pkg;

  // Default width of the integer accumulator
  localparam int INT_BITS_DEF = 32;
  // Fraction bits in the reported fraction (accumulator is Q0.40)
  localparam int FRAC_BITS = 32;
  localparam int ACC_FRAC_BITS = 40;
  localparam int WEIGHT_BITS = 37;
  // Fraction digits after which the weight has decayed to zero
  localparam int WEIGHT_STEPS = 12;
  localparam int WCNT_BITS = 4;

  // Character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_SATURATE = 2'd2
  } status_t;

  // One result word
  typedef struct packed {
    logic [31:0] int_value;
    logic [31:0] frac_value;
    status_t     status;
    logic [7:0]  bad_char;
  } result_t;

  // Weight of the next fraction digit in Q0.40: one tenth, divided by ten
  // (truncating) after each digit.
  function automatic logic [WEIGHT_BITS-1:0] digit_weight(input logic [WCNT_BITS-1:0] cnt);
    logic [WEIGHT_BITS-1:0] w;
    unique case (cnt)
      4'd0:    w = 37'd109951162778;
      4'd1:    w = 37'd10995116277;
      4'd2:    w = 37'd1099511627;
      4'd3:    w = 37'd109951162;
      4'd4:    w = 37'd10995116;
      4'd5:    w = 37'd1099511;
      4'd6:    w = 37'd109951;
      4'd7:    w = 37'd10995;
      4'd8:    w = 37'd1099;
      4'd9:    w = 37'd109;
      4'd10:   w = 37'd10;
      4'd11:   w = 37'd1;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/adnp_in_reg.sv
// Input register of the ASCII decimal number parser.
// Holds one accepted byte until the parser core takes it.
module adnp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       take,
  output logic       q_valid,
  output logic [7:0] q_byte
);

  logic q_valid_next;
  logic load;

  // Stall only while a held byte cannot move on
  assign in_stall = q_valid && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    if (load) begin
      q_valid_next = 1'b1;
    end else if (take) begin
      q_valid_next = 1'b0;
    end else begin
      q_valid_next = q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= q_valid_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      q_byte <= byte_in;
    end
  end

endmodule

>>> hw/rtl/adnp_core.sv
// Parser core: phase state machine, integer and fraction accumulators.
// Consumes one byte per cycle from the input register, except while a result waits for room. Uses adnp_pkg.
module adnp_core #(
  parameter int INT_BITS = adnp_pkg::INT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [7:0]        item_byte,
  input  logic              res_free,
  output logic              item_take,
  output logic              res_load,
  output adnp_pkg::result_t res
);

  localparam int ACC_W = adnp_pkg::ACC_FRAC_BITS;
  localparam int WB    = adnp_pkg::WEIGHT_BITS;
  localparam int CB    = adnp_pkg::WCNT_BITS;

  adnp_pkg::phase_t phase, phase_next;
  logic [INT_BITS-1:0] int_acc, int_acc_next;
  logic                int_sat, int_sat_next;
  logic [ACC_W-1:0]    frac_acc, frac_acc_next;
  logic [CB-1:0]       wcnt, wcnt_next;

  // Character classes
  logic       is_space, is_sep, is_digit;
  logic [3:0] digit;

  assign is_space = (item_byte == adnp_pkg::CH_SPACE) || (item_byte == adnp_pkg::CH_NEWLINE);
  assign is_sep   = (item_byte == adnp_pkg::CH_COMMA) || (item_byte == adnp_pkg::CH_DOT);
  assign is_digit = (item_byte >= adnp_pkg::CH_ZERO) && (item_byte <= adnp_pkg::CH_NINE);
  assign digit    = item_byte[3:0];

  // Decoded actions for the current byte
  logic emit, emit_err, do_int, do_frac;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      adnp_pkg::PH_INT: begin
        if (is_space || !(is_sep || is_digit)) phase_next = adnp_pkg::PH_SKIP;
        else if (is_sep)                      phase_next = adnp_pkg::PH_FRAC;
        else                                  phase_next = adnp_pkg::PH_INT;
      end
      adnp_pkg::PH_FRAC: begin
        if (is_digit) phase_next = adnp_pkg::PH_FRAC;
        else          phase_next = adnp_pkg::PH_SKIP;
      end
      default: begin
        if (is_sep)        phase_next = adnp_pkg::PH_FRAC;
        else if (is_digit) phase_next = adnp_pkg::PH_INT;
        else               phase_next = adnp_pkg::PH_SKIP;
      end
    endcase
  end

  // Actions
  always_comb begin
    emit     = 1'b0;
    emit_err = 1'b0;
    do_int   = 1'b0;
    do_frac  = 1'b0;
    unique case (phase)
      adnp_pkg::PH_INT: begin
        emit     = !is_digit && !is_sep;
        emit_err = emit && !is_space;
        do_int   = is_digit;
      end
      adnp_pkg::PH_FRAC: begin
        emit     = !is_digit;
        emit_err = emit && !is_space;
        do_frac  = is_digit;
      end
      default: begin
        emit     = !is_space && !is_sep && !is_digit;
        emit_err = emit;
        do_int   = is_digit;
      end
    endcase
  end

  // Handshake with input and output registers
  assign item_take = item_valid && (!emit || res_free);
  assign res_load  = item_take && emit;

  // Integer digit: acc*10 + d, saturating
  logic [INT_BITS+3:0] int_prod;
  logic                int_ovf;

  assign int_prod = {1'b0, int_acc, 3'b000} + {3'b000, int_acc, 1'b0}
                  + {{INT_BITS{1'b0}}, digit};
  assign int_ovf  = |int_prod[INT_BITS+3:INT_BITS];

  // Fraction digit: frac_acc + d * weight, saturating at 40 bits
  logic [WB-1:0]    weight;
  logic [WB+3:0]    frac_prod;
  logic [ACC_W+1:0] frac_sum;

  assign weight    = adnp_pkg::digit_weight(wcnt);
  // Full-width product; 9 * weight needs more bits than the weight itself
  assign frac_prod = {{WB{1'b0}}, digit} * {4'b0000, weight};
  assign frac_sum  = {2'b00, frac_acc} + (ACC_W+2)'(frac_prod);

  // Accumulator next values
  always_comb begin
    int_acc_next  = int_acc;
    int_sat_next  = int_sat;
    frac_acc_next = frac_acc;
    wcnt_next     = wcnt;
    if (emit) begin
      int_acc_next  = '0;
      int_sat_next  = 1'b0;
      frac_acc_next = '0;
      wcnt_next     = '0;
    end else if (do_int) begin
      if (int_sat || int_ovf) begin
        int_acc_next = '1;
        int_sat_next = 1'b1;
      end else begin
        int_acc_next = int_prod[INT_BITS-1:0];
      end
    end else if (do_frac) begin
      frac_acc_next = (|frac_sum[ACC_W+1:ACC_W]) ? '1 : frac_sum[ACC_W-1:0];
      if (wcnt != CB'(adnp_pkg::WEIGHT_STEPS)) wcnt_next = wcnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= adnp_pkg::PH_SKIP;
      int_acc  <= '0;
      int_sat  <= 1'b0;
      frac_acc <= '0;
      wcnt     <= '0;
    end else if (item_take) begin
      phase    <= phase_next;
      int_acc  <= int_acc_next;
      int_sat  <= int_sat_next;
      frac_acc <= frac_acc_next;
      wcnt     <= wcnt_next;
    end
  end

  // Rescale the Q0.40 accumulator to the reported fraction width
  logic [31:0] frac_out;
  generate
    if (adnp_pkg::FRAC_BITS <= ACC_W) begin : g_frac_shr
      assign frac_out = 32'(frac_acc >> (ACC_W - adnp_pkg::FRAC_BITS));
    end else begin : g_frac_shl
      assign frac_out = 32'(frac_acc << (adnp_pkg::FRAC_BITS - ACC_W));
    end
  endgenerate

  // Result word
  always_comb begin
    if (emit_err) begin
      res.int_value  = '0;
      res.frac_value = '0;
      res.status     = adnp_pkg::ST_BAD_CHAR;
      res.bad_char   = item_byte;
    end else begin
      res.int_value  = 32'(int_acc);
      res.frac_value = frac_out;
      res.status     = int_sat ? adnp_pkg::ST_SATURATE : adnp_pkg::ST_OK;
      res.bad_char   = '0;
    end
  end

endmodule

>>> hw/rtl/adnp_out_reg.sv
// Output register of the ASCII decimal number parser.
// Holds one result word until the receiver takes it. Uses adnp_pkg.
module adnp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  adnp_pkg::result_t res_in,
  output logic              res_free,
  output logic              out_valid,
  input  logic              out_stall,
  output adnp_pkg::result_t res_q
);

  logic out_valid_next;

  // Room for a new word when empty or draining this cycle
  assign res_free = !out_valid || !out_stall;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

>>> hw/rtl/ascii_decimal_number_parser.sv
// Top level of the ASCII decimal number parser.
// Instantiates adnp_in_reg, adnp_core and adnp_out_reg; uses adnp_pkg.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    byte_in[7:0]
//   out      out  out_valid/out_stall  int_value[31:0] frac_value[31:0]
//                                      status[1:0] bad_char[7:0]
//
// One byte per cycle sustained, except while a result-producing byte waits
// for the result register; the byte that ends a number is held in the input
// register, then its result word is loaded into the result register and is valid.
// Bytes that produce no result keep flowing while a result waits stalled;
// a result-producing byte waits in the input register until the result
// register frees up. Reset is synchronous and clears all parse state.
module ascii_decimal_number_parser #(
  parameter int INT_BITS = adnp_pkg::INT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] int_value,
  output logic [31:0] frac_value,
  output logic [1:0]  status,
  output logic [7:0]  bad_char
);

  logic              q_valid;
  logic [7:0]        q_byte;
  logic              take;
  logic              res_load;
  logic              res_free;
  adnp_pkg::result_t res_word;
  adnp_pkg::result_t res_q;

  adnp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .byte_in  (byte_in),
    .take     (take),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  adnp_core #(
    .INT_BITS (INT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_byte  (q_byte),
    .res_free   (res_free),
    .item_take  (take),
    .res_load   (res_load),
    .res        (res_word)
  );

  adnp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res_word),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign int_value  = res_q.int_value;
  assign frac_value = res_q.frac_value;
  assign status     = res_q.status;
  assign bad_char   = res_q.bad_char;

  // Error words carry no number
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == adnp_pkg::ST_BAD_CHAR) |-> (int_value == '0) && (frac_value == '0))
    else $error("error word with nonzero number");

  // Only error words carry a character
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != adnp_pkg::ST_BAD_CHAR) |-> (bad_char == '0))
    else $error("bad_char set on a good word");

  // Input stalls only while a byte is held and blocked by a full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A new result is loaded only when the output register has room
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> res_free)
    else $error("result register overwritten");

endmodule
